// File: hdl/tprb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the two-pole resonator bank
// used by tprb_datapath and two_pole_resonator_bank_top; no dependencies

package tprb_pkg;

    localparam int DEF_NUM_RESONATORS = 64;
    localparam int DEF_SAMPLE_WIDTH   = 24;
    localparam int DEF_COEF_WIDTH     = 24;

    localparam int COUNT_W     = 7;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int RES_INDEX_W = 6;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HARD_LIMIT   = 2'd2;

    localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST = 7'd1;
    localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST  = 16'd4096;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_acc;
        logic rd_vld;
    } tprb_ctl_t;

endpackage

// File: hdl/tprb_datapath.sv
`timescale 1ns / 1ps
// resonator arithmetic pipeline: products, saturated output, gain, clip and sum
// depends on tprb_pkg

module tprb_datapath #(
    parameter int NUM_RESONATORS = tprb_pkg::DEF_NUM_RESONATORS,
    parameter int SAMPLE_WIDTH   = tprb_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = tprb_pkg::DEF_COEF_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tprb_pkg::tprb_ctl_t            ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] last_out,
    input  logic signed [SAMPLE_WIDTH-1:0] prior_out,
    input  logic signed [COEF_WIDTH-1:0]   coef_b1,
    input  logic signed [COEF_WIDTH-1:0]   coef_b2,
    input  logic signed [COEF_WIDTH-1:0]   coef_a1,
    input  logic signed [SAMPLE_WIDTH-1:0] excitation,
    input  logic [tprb_pkg::GAIN_W-1:0]    output_gain,
    input  logic signed [SAMPLE_WIDTH-1:0] hard_limit,
    output logic signed [SAMPLE_WIDTH-1:0] y_out,
    output logic                           busy,
    output logic signed [SAMPLE_WIDTH-1:0] bank_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int PW    = SW + CW;
    localparam int TW    = SW + 2;
    localparam int YS_W  = SW + 4;
    localparam int GP_W  = SW + tprb_pkg::GAIN_W + 1;
    localparam int V_W   = GP_W - tprb_pkg::GAIN_FRAC;
    localparam int IDX_W = (NUM_RESONATORS > 1) ? $clog2(NUM_RESONATORS) : 1;
    localparam int ACC_W = V_W + IDX_W + 1;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic signed [PW-1:0]    prod_b1_reg, prod_b2_reg, prod_a1_reg;
    logic signed [PW-1:0]    prod_b1_next, prod_b2_next, prod_a1_next;
    logic                    p_vld_reg;
    logic signed [TW-1:0]    term_b1, term_b2, term_a1;
    logic signed [YS_W-1:0]  y_sum;
    logic signed [SW-1:0]    y_sat;
    logic signed [SW-1:0]    y_reg;
    logic                    y_vld_reg;
    logic signed [tprb_pkg::GAIN_W:0] gain_s;
    logic signed [GP_W-1:0]  gprod_reg, gprod_next;
    logic                    v_vld_reg;
    logic signed [V_W-1:0]   v_val, v_lim, v_clip;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] acc_lim, sum_clip;

    // stage 1: the three products
    assign prod_b1_next = coef_b1 * last_out;
    assign prod_b2_next = coef_b2 * prior_out;
    assign prod_a1_next = coef_a1 * excitation;

    // stage 2: floor shift, exact add, saturate
    assign term_b1 = $signed(prod_b1_reg[PW-1:CW-2]);
    assign term_b2 = $signed(prod_b2_reg[PW-1:CW-2]);
    assign term_a1 = $signed(prod_a1_reg[PW-1:CW-2]);
    assign y_sum   = YS_W'(term_b1) + YS_W'(term_b2) + YS_W'(term_a1);

    always_comb begin
        if (y_sum > YS_W'(S_MAX)) begin
            y_sat = S_MAX;
        end else if (y_sum < YS_W'(S_MIN)) begin
            y_sat = S_MIN;
        end else begin
            y_sat = y_sum[SW-1:0];
        end
    end

    assign y_out = y_sat;

    // stage 3: output gain
    assign gain_s     = $signed({1'b0, output_gain});
    assign gprod_next = y_reg * gain_s;

    // stage 4: clip from above and accumulate
    assign v_val  = $signed(gprod_reg[GP_W-1:tprb_pkg::GAIN_FRAC]);
    assign v_lim  = V_W'(hard_limit);
    assign v_clip = (v_val > v_lim) ? v_lim : v_val;

    always_comb begin
        if (ctl.clear_acc) begin
            acc_next = '0;
        end else if (v_vld_reg) begin
            acc_next = acc_reg + ACC_W'(v_clip);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_b1_reg <= prod_b1_next;
        prod_b2_reg <= prod_b2_next;
        prod_a1_reg <= prod_a1_next;
        y_reg       <= y_sat;
        gprod_reg   <= gprod_next;
        acc_reg     <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            y_vld_reg <= 1'b0;
            v_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= ctl.rd_vld;
            y_vld_reg <= p_vld_reg;
            v_vld_reg <= y_vld_reg;
        end
    end

    assign busy = ctl.rd_vld | p_vld_reg | y_vld_reg | v_vld_reg;

    // final clip and saturation of the sum
    assign acc_lim  = ACC_W'(hard_limit);
    assign sum_clip = (acc_reg > acc_lim) ? acc_lim : acc_reg;

    always_comb begin
        if (sum_clip > ACC_W'(S_MAX)) begin
            bank_out = S_MAX;
        end else if (sum_clip < ACC_W'(S_MIN)) begin
            bank_out = S_MIN;
        end else begin
            bank_out = sum_clip[SW-1:0];
        end
    end

endmodule

// File: hdl/two_pole_resonator_bank_top.sv
`timescale 1ns / 1ps
// top level of the two-pole resonator bank: stream ports, config registers,
// state memory and sequencer; depends on tprb_pkg and tprb_datapath

// A bank of two-pole resonators driven by one shared excitation sample. All
// per-resonator state (two history values, pending and active coefficients)
// lives in one single-port-read, single-port-write memory, and resonators are
// processed one per cycle through the product, saturate, gain and accumulate
// stages of the arithmetic pipeline. The result of a sample transfer
// (tuser = 0) goes to the output register once every active resonator has
// been read from the state memory, one per cycle, and the pipeline has drained.
// A coefficient load (tuser = 1) does a read, a merge and a write back and
// gives no result; a load takes effect from the sample after next use. After
// reset a clearing pass zeroes every memory entry; input is not accepted
// during it, config writes are. The result sits in an output register, so the
// bank goes on with a load while a result waits.

module two_pole_resonator_bank_top #(
    parameter int NUM_RESONATORS = tprb_pkg::DEF_NUM_RESONATORS,
    parameter int SAMPLE_WIDTH   = tprb_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH     = tprb_pkg::DEF_COEF_WIDTH,
    localparam int IN_W   = tprb_pkg::RES_INDEX_W + 3 * COEF_WIDTH + SAMPLE_WIDTH,
    localparam int TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int CFG_DW = (SAMPLE_WIDTH > tprb_pkg::GAIN_W) ? SAMPLE_WIDTH
                                                              : tprb_pkg::GAIN_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // res_index, coef_b1, coef_b2, coef_a1, excitation, zero fill
    input  logic [TDATA_W-1:0]               s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bank_out, zero fill
    output logic [OUT_W-1:0]                 m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [tprb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]                cfg_wdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int RIW   = tprb_pkg::RES_INDEX_W;
    localparam int IDX_W = (NUM_RESONATORS > 1) ? $clog2(NUM_RESONATORS) : 1;
    localparam int CNT_W = $clog2(NUM_RESONATORS + 1);
    localparam int XW    = ((IDX_W > RIW) ? IDX_W : RIW) + 1;
    localparam int CMP_W = (CNT_W > tprb_pkg::COUNT_W) ? CNT_W : tprb_pkg::COUNT_W;
    localparam int E_W   = 2 * SW + 6 * CW;

    // entry layout from the lowest bit: last, prior, active b1 b2 a1, pending b1 b2 a1
    localparam int OFF_LAST  = 0;
    localparam int OFF_PRIOR = SW;
    localparam int OFF_ACT   = 2 * SW;
    localparam int OFF_PEND  = 2 * SW + 3 * CW;

    localparam int OFF_B1 = RIW;
    localparam int OFF_B2 = RIW + CW;
    localparam int OFF_A1 = RIW + 2 * CW;
    localparam int OFF_X  = RIW + 3 * CW;

    localparam logic [SW-1:0] HL_RST = {1'b0, {(SW-1){1'b1}}};

    tprb_pkg::state_t state_reg, state_next;

    logic [tprb_pkg::COUNT_W-1:0] active_count_reg;
    logic [tprb_pkg::GAIN_W-1:0]  output_gain_reg;
    logic signed [SW-1:0]         hard_limit_reg;

    logic [E_W-1:0]      mem [NUM_RESONATORS];
    logic [E_W-1:0]      rd_data_reg;
    logic                rd_vld_reg, rd_vld_next;
    logic                mem_re, mem_we;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    logic [IDX_W-1:0]    rd_addr_q;
    logic [E_W-1:0]      wr_data;

    logic [CNT_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0]    cnt_lim_reg;
    logic [CNT_W-1:0]    cnt_eff;
    logic [IDX_W-1:0]    ld_idx_reg;
    logic [3*CW-1:0]     ld_coef_reg;
    logic signed [SW-1:0] x_reg;

    logic                wb_vld_reg;
    logic [IDX_W-1:0]    wb_idx_reg;
    logic [3*CW-1:0]     wb_pend_reg;
    logic [SW-1:0]       wb_last_reg;

    logic                in_xfer;
    logic                in_range;
    logic                out_load;
    logic                out_vld_reg;
    logic [SW-1:0]       out_data_reg;

    tprb_pkg::tprb_ctl_t  dp_ctl;
    logic signed [SW-1:0] dp_y;
    logic signed [SW-1:0] dp_bank_out;
    logic                 dp_busy;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= tprb_pkg::ACTIVE_COUNT_RST;
            output_gain_reg  <= tprb_pkg::OUTPUT_GAIN_RST;
            hard_limit_reg   <= HL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tprb_pkg::CFG_ACTIVE_COUNT: active_count_reg <= cfg_wdata[tprb_pkg::COUNT_W-1:0];
                tprb_pkg::CFG_OUTPUT_GAIN:  output_gain_reg  <= cfg_wdata[tprb_pkg::GAIN_W-1:0];
                tprb_pkg::CFG_HARD_LIMIT:   hard_limit_reg   <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // active count saturated to the bank size
    always_comb begin
        if (CMP_W'(active_count_reg) > CMP_W'(NUM_RESONATORS)) begin
            cnt_eff = CNT_W'(NUM_RESONATORS);
        end else begin
            cnt_eff = CNT_W'(active_count_reg);
        end
    end

    assign in_xfer  = s_tvalid & s_tready;
    assign in_range = XW'(s_tdata[RIW-1:0]) < XW'(NUM_RESONATORS);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tprb_pkg::ST_CLEAR: begin
                if (clr_idx_reg == CNT_W'(NUM_RESONATORS - 1)) begin
                    state_next = tprb_pkg::ST_IDLE;
                end
            end
            tprb_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == tprb_pkg::CMD_LOAD) begin
                        state_next = in_range ? tprb_pkg::ST_LD_RD : tprb_pkg::ST_IDLE;
                    end else if (cnt_eff == '0) begin
                        state_next = tprb_pkg::ST_DRAIN;
                    end else begin
                        state_next = tprb_pkg::ST_RUN;
                    end
                end
            end
            tprb_pkg::ST_LD_RD: state_next = tprb_pkg::ST_LD_WR;
            tprb_pkg::ST_LD_WR: state_next = tprb_pkg::ST_IDLE;
            tprb_pkg::ST_RUN: begin
                if (issue_idx_reg == cnt_lim_reg - CNT_W'(1)) begin
                    state_next = tprb_pkg::ST_DRAIN;
                end
            end
            tprb_pkg::ST_DRAIN: begin
                if (!dp_busy) begin
                    state_next = tprb_pkg::ST_DONE;
                end
            end
            tprb_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = tprb_pkg::ST_IDLE;
                end
            end
            default: state_next = tprb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready       = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = issue_idx_reg[IDX_W-1:0];
        wr_addr        = wb_idx_reg;
        wr_data        = {wb_pend_reg, wb_pend_reg, wb_last_reg, dp_y};
        rd_vld_next    = 1'b0;
        issue_idx_next = issue_idx_reg;
        clr_idx_next   = clr_idx_reg;
        out_load       = 1'b0;
        dp_ctl.clear_acc = 1'b0;
        dp_ctl.rd_vld    = rd_vld_reg;
        case (state_reg)
            tprb_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                wr_addr      = clr_idx_reg[IDX_W-1:0];
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + CNT_W'(1);
            end
            tprb_pkg::ST_IDLE: begin
                s_tready         = 1'b1;
                issue_idx_next   = '0;
                dp_ctl.clear_acc = in_xfer & (s_tuser == tprb_pkg::CMD_SAMPLE);
            end
            tprb_pkg::ST_LD_RD: begin
                mem_re  = 1'b1;
                rd_addr = ld_idx_reg;
            end
            tprb_pkg::ST_LD_WR: begin
                mem_we  = 1'b1;
                wr_addr = ld_idx_reg;
                wr_data = {ld_coef_reg, rd_data_reg[OFF_PEND-1:0]};
            end
            tprb_pkg::ST_RUN: begin
                mem_re         = 1'b1;
                rd_vld_next    = 1'b1;
                issue_idx_next = issue_idx_reg + CNT_W'(1);
                mem_we         = wb_vld_reg;
            end
            tprb_pkg::ST_DRAIN: begin
                mem_we = wb_vld_reg;
            end
            tprb_pkg::ST_DONE: begin
                out_load = ~out_vld_reg | m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tprb_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            wb_vld_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            wb_vld_reg    <= rd_vld_reg;
        end
    end

    // transfer payload capture
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ld_idx_reg  <= IDX_W'(s_tdata[RIW-1:0]);
            ld_coef_reg <= s_tdata[OFF_X-1:OFF_B1];
            x_reg       <= s_tdata[OFF_X+SW-1:OFF_X];
            cnt_lim_reg <= cnt_eff;
        end
    end

    // state memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // write-back fields follow the product stage
    always_ff @(posedge aclk) begin
        wb_idx_reg  <= rd_addr_q;
        wb_pend_reg <= rd_data_reg[E_W-1:OFF_PEND];
        wb_last_reg <= rd_data_reg[OFF_LAST+SW-1:OFF_LAST];
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_addr_q <= rd_addr;
        end
    end

    tprb_datapath #(
        .NUM_RESONATORS (NUM_RESONATORS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (dp_ctl),
        .last_out    (rd_data_reg[OFF_LAST+SW-1:OFF_LAST]),
        .prior_out   (rd_data_reg[OFF_PRIOR+SW-1:OFF_PRIOR]),
        .coef_b1     (rd_data_reg[OFF_ACT+CW-1:OFF_ACT]),
        .coef_b2     (rd_data_reg[OFF_ACT+2*CW-1:OFF_ACT+CW]),
        .coef_a1     (rd_data_reg[OFF_ACT+3*CW-1:OFF_ACT+2*CW]),
        .excitation  (x_reg),
        .output_gain (output_gain_reg),
        .hard_limit  (hard_limit_reg),
        .y_out       (dp_y),
        .busy        (dp_busy),
        .bank_out    (dp_bank_out)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= dp_bank_out;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

`ifndef ASSERT_OFF
    a_wb_in_sample : assert property (@(posedge aclk) disable iff (!aresetn)
        wb_vld_reg |-> (state_reg == tprb_pkg::ST_RUN || state_reg == tprb_pkg::ST_DRAIN))
        else $error("write-back outside a sample run");

    a_issue_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tprb_pkg::ST_RUN |-> issue_idx_reg < cnt_lim_reg)
        else $error("resonator index beyond active count");

    a_done_drained : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tprb_pkg::ST_DONE |-> !dp_busy && !wb_vld_reg)
        else $error("result taken before pipeline drained");
`endif

endmodule

// File: tb/tprb_checker.sv
`timescale 1ns / 1ps
// checker for the two-pole resonator bank: watches the input, result and config ports,
// predicts each bank output and compares it with what the block returns
// depends on tprb_pkg

module tprb_checker #(
    parameter int NRES = tprb_pkg::DEF_NUM_RESONATORS,
    parameter int SW   = tprb_pkg::DEF_SAMPLE_WIDTH,
    parameter int CW   = tprb_pkg::DEF_COEF_WIDTH,
    parameter int TDW  = 104,
    parameter int OW   = 24,
    parameter int CDW  = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // res_index, coef_b1, coef_b2, coef_a1, excitation, zero fill
    input  logic [TDW-1:0]                   s_tdata,
    // cmd
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // bank_out, zero fill
    input  logic [OW-1:0]                    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [tprb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CDW-1:0]                   cfg_wdata,
    input  logic                             final_check,
    output int                               fail_count,
    output int                               outstanding,
    output int                               results_checked
);
    import tprb_pkg::*;

    localparam longint SMP_HI = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SMP_LO = -SMP_HI - 1;

    logic signed [SW-1:0] last_y  [NRES];
    logic signed [SW-1:0] prior_y [NRES];
    logic signed [CW-1:0] next_b1 [NRES];
    logic signed [CW-1:0] next_b2 [NRES];
    logic signed [CW-1:0] next_a1 [NRES];
    logic signed [CW-1:0] live_b1 [NRES];
    logic signed [CW-1:0] live_b2 [NRES];
    logic signed [CW-1:0] live_a1 [NRES];
    logic [COUNT_W-1:0]   bank_size;
    logic [GAIN_W-1:0]    res_gain;
    logic signed [SW-1:0] clip_level;
    logic signed [SW-1:0] bank_out_due [$];
    bit                   final_done;

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint clamp_sample(longint v);
        if (v > SMP_HI)
            return SMP_HI;
        if (v < SMP_LO)
            return SMP_LO;
        return v;
    endfunction

    // runs every active resonator on one excitation sample and updates its state
    function automatic logic signed [SW-1:0] run_bank_sample(logic signed [SW-1:0] x);
        longint y;
        longint v;
        longint total;
        int     n;
        n = (int'(bank_size) > NRES) ? NRES : int'(bank_size);
        total = 0;
        for (int i = 0; i < n; i++) begin
            y = ((longint'(live_b1[i]) * longint'(last_y[i])) >>> (CW - 2))
              + ((longint'(live_b2[i]) * longint'(prior_y[i])) >>> (CW - 2))
              + ((longint'(live_a1[i]) * longint'(x)) >>> (CW - 2));
            y = clamp_sample(y);
            prior_y[i] = last_y[i];
            last_y[i]  = y[SW-1:0];
            live_b1[i] = next_b1[i];
            live_b2[i] = next_b2[i];
            live_a1[i] = next_a1[i];
            v = (y * longint'(res_gain)) >>> GAIN_FRAC;
            if (v > longint'(clip_level))
                v = longint'(clip_level);
            total += v;
        end
        if (total > longint'(clip_level))
            total = longint'(clip_level);
        total = clamp_sample(total);
        return total[SW-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        logic signed [SW-1:0]    got;
        logic signed [SW-1:0]    want;
        logic [RES_INDEX_W-1:0]  idx;
        if (!aresetn) begin
            for (int i = 0; i < NRES; i++) begin
                last_y[i]  = '0;
                prior_y[i] = '0;
                next_b1[i] = '0;
                next_b2[i] = '0;
                next_a1[i] = '0;
                live_b1[i] = '0;
                live_b2[i] = '0;
                live_a1[i] = '0;
            end
            bank_size       = ACTIVE_COUNT_RST;
            res_gain        = OUTPUT_GAIN_RST;
            clip_level      = SMP_HI[SW-1:0];
            bank_out_due.delete();
            fail_count      = 0;
            results_checked = 0;
            final_done      = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ACTIVE_COUNT: bank_size  = cfg_wdata[COUNT_W-1:0];
                    CFG_OUTPUT_GAIN:  res_gain   = cfg_wdata[GAIN_W-1:0];
                    CFG_HARD_LIMIT:   clip_level = cfg_wdata[SW-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[SW-1:0];
                if (bank_out_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with nothing expected", got));
                end else begin
                    want = bank_out_due.pop_front();
                    results_checked++;
                    if (got !== want)
                        flag_mismatch($sformatf("bank_out %0d, expected %0d", got, want));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    idx = s_tdata[RES_INDEX_W-1:0];
                    if (int'(idx) < NRES) begin
                        next_b1[idx] = s_tdata[RES_INDEX_W +: CW];
                        next_b2[idx] = s_tdata[RES_INDEX_W + CW +: CW];
                        next_a1[idx] = s_tdata[RES_INDEX_W + 2 * CW +: CW];
                    end
                end else begin
                    bank_out_due = {bank_out_due,
                                    run_bank_sample(s_tdata[RES_INDEX_W + 3 * CW +: SW])};
                end
            end
            if (final_check && !final_done) begin
                if (bank_out_due.size() != 0)
                    flag_mismatch($sformatf("%0d results never arrived",
                                            bank_out_due.size()));
                final_done = 1'b1;
            end
        end
        outstanding = bank_out_due.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench top for the two-pole resonator bank: clock, reset, stimulus and verdict
// depends on tprb_pkg, two_pole_resonator_bank_top and tprb_checker

module tb;
    import tprb_pkg::*;

    localparam int NRES = DEF_NUM_RESONATORS;
    localparam int SW   = DEF_SAMPLE_WIDTH;
    localparam int CW   = DEF_COEF_WIDTH;
    localparam int IN_W = RES_INDEX_W + 3 * CW + SW;
    localparam int TDW  = ((IN_W + 7) / 8) * 8;
    localparam int OW   = ((SW + 7) / 8) * 8;
    localparam int CDW  = (SW > GAIN_W) ? SW : GAIN_W;

    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam int                   UNITY = 1 << (CW - 2);

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDW-1:0]         s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OW-1:0]          m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CDW-1:0]         cfg_wdata;

    logic final_check;
    int   fail_count;
    int   outstanding;
    int   results_checked;
    bit   steady;
    bit   hold_request;
    int   cur_count;
    int   loads_sent;
    int   samples_sent;
    int   settings_used;

    two_pole_resonator_bank_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tprb_checker #(
        .NRES (NRES),
        .SW   (SW),
        .CW   (CW),
        .TDW  (TDW),
        .OW   (OW),
        .CDW  (CDW)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .final_check     (final_check),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #10ms;
        $display("timeout at %0t ns", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random back-pressure, or one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 38);
                @(posedge aclk);
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_word();
        rand_word = CW'($urandom);
    endfunction

    task automatic offer(logic cmd, logic [RES_INDEX_W-1:0] idx, logic signed [CW-1:0] b1,
                         logic signed [CW-1:0] b2, logic signed [CW-1:0] a1,
                         logic signed [SW-1:0] x);
        logic [TDW-1:0] payload;
        payload = '0;
        payload[IN_W-1:0] = {x, a1, b2, b1, idx};
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_LOAD)
            loads_sent++;
        else
            samples_sent++;
    endtask

    // unused fields carry random bits so that the block is seen to ignore them
    task automatic push_load(int idx, logic signed [CW-1:0] b1, logic signed [CW-1:0] b2,
                             logic signed [CW-1:0] a1);
        offer(CMD_LOAD, idx[RES_INDEX_W-1:0], b1, b2, a1, rand_word());
    endtask

    task automatic push_sample(logic signed [SW-1:0] x);
        offer(CMD_SAMPLE, RES_INDEX_W'($urandom), rand_word(), rand_word(), rand_word(), x);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CDW'(value);
        @(posedge aclk);
    endtask

    // wait for every result, then let any load still in flight finish
    task automatic settle();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (NRES + 16) @(posedge aclk);
    endtask

    task automatic set_bank(int count, int gain, int limit);
        settle();
        write_reg(CFG_ACTIVE_COUNT, count);
        write_reg(CFG_OUTPUT_GAIN, gain);
        write_reg(CFG_HARD_LIMIT, limit);
        cfg_wr_en <= 1'b0;
        cur_count = count;
        settings_used++;
    endtask

    task automatic random_item();
        int k;
        int span;
        int idx;
        int n;
        logic signed [CW-1:0] b1;
        logic signed [CW-1:0] b2;
        logic signed [CW-1:0] a1;
        logic signed [SW-1:0] x;
        if ($urandom_range(99) < 30) begin
            n = (cur_count > NRES) ? NRES : cur_count;
            if (n > 0 && $urandom_range(99) < 60)
                idx = $urandom_range(n - 1);
            else
                idx = $urandom_range(NRES - 1);
            if ($urandom_range(99) < 70) begin
                // poles inside the unit circle so the history stays alive
                k    = $urandom_range(4150000, 2000000);
                span = UNITY + k - 1;
                b2   = CW'(-k);
                b1   = CW'(int'($urandom_range(2 * span)) - span);
                a1   = CW'(int'($urandom_range(2 * UNITY / 2)) - UNITY / 2);
            end else begin
                b1 = rand_word();
                b2 = rand_word();
                a1 = rand_word();
            end
            push_load(idx, b1, b2, a1);
        end else begin
            case ($urandom_range(9))
                0:       x = SMP_MAX;
                1:       x = SMP_MIN;
                2:       x = '0;
                3:       x = SW'(int'($urandom_range(2000)) - 1000);
                default: x = rand_word();
            endcase
            push_sample(x);
        end
    endtask

    task automatic run_phase(int count, int gain, int limit, int items, bit quiet,
                             bit stall);
        set_bank(count, gain, limit);
        steady = quiet;
        if (stall)
            hold_request = 1'b1;
        repeat (items) random_item();
        s_tvalid <= 1'b0;
        steady = 1'b0;
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= CMD_SAMPLE;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_ACTIVE_COUNT;
        cfg_wdata    <= '0;
        final_check   = 1'b0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        cur_count     = 1;
        loads_sent    = 0;
        samples_sent  = 0;
        settings_used = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: coefficient and sample extremes, a late-taking load, an idle resonator
        set_bank(4, 4096, int'(SMP_MAX));
        push_load(0, COEF_MAX, COEF_MIN, COEF_MAX);
        push_load(1, COEF_MIN, COEF_MAX, COEF_MIN);
        push_load(2, '0, '0, CW'(UNITY));
        push_load(3, CW'(3500000), CW'(-3900000), CW'(UNITY / 4));
        push_load(NRES - 1, CW'(UNITY), '0, CW'(UNITY));
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample('0);
        push_sample(SW'(-1));
        push_sample(SW'(1));
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample(24'sh123456);
        push_load(2, '0, '0, CW'(-UNITY));
        push_sample(SW'(1000));
        push_sample(SW'(1000));
        push_sample(SW'(-1000));
        s_tvalid <= 1'b0;

        run_phase(8, 4096, int'(SMP_MAX), 120, 1'b0, 1'b1);
        run_phase(NRES, 65535, int'(SMP_MAX), 50, 1'b0, 1'b0);
        run_phase(0, 4096, -5, 30, 1'b0, 1'b0);
        run_phase(0, 300, 7000, 10, 1'b0, 1'b0);
        run_phase(127, 0, 0, 30, 1'b0, 1'b0);
        run_phase(NRES + 1, 4096, int'(SMP_MAX), 30, 1'b0, 1'b0);
        run_phase(5, $urandom_range(65535), int'(rand_word()), 160, 1'b1, 1'b0);
        run_phase(1, 4096, int'(SMP_MIN), 40, 1'b0, 1'b0);
        run_phase(2, 65535, 12345, 60, 1'b0, 1'b0);
        repeat (4)
            run_phase($urandom_range(NRES, 1), $urandom_range(65535),
                      ($urandom_range(1)) ? int'(rand_word()) : $urandom_range(SMP_MAX),
                      75, 1'b0, 1'b0);

        @(posedge aclk);
        for (int k = 0; k < 50000 && outstanding != 0; k++) @(posedge aclk);
        repeat (NRES + 16) @(posedge aclk);
        final_check = 1'b1;
        repeat (2) @(posedge aclk);

        $display("covered %0d coefficient loads and %0d samples (%0d results checked)",
                 loads_sent, samples_sent, results_checked);
        $display("over %0d bank settings: active counts 0 to 127, gain 0 to 65535, both clip ends",
                 settings_used);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
